// ===== hdl/mps_pkg.sv =====
// Shared types, constants and control structs for the Mandelbrot pixel shader.
package mps_pkg;

    // Fixed-point format: signed Q4.28
    localparam int FRAC_BITS = 28;
    localparam int INT_BITS  = 4;
    localparam int VAL_W     = FRAC_BITS + INT_BITS;

    // Field widths
    localparam int COORD_W = 12;
    localparam int ITER_W  = 10;
    localparam int CFG_W   = 13;
    localparam int GRAY_W  = 8;

    // Iteration count clamp default
    localparam int MAX_ITER_LIMIT_DEF = 1023;

    // Step counter covers the coordinate divider and the gray divider
    localparam int CNT_W = $clog2(VAL_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    // Configuration reset values
    localparam logic [ITER_W-1:0] RST_MAX_ITER = 10'd50;
    localparam logic [CFG_W-1:0]  RST_WIDTH    = 13'd800;
    localparam logic [CFG_W-1:0]  RST_HEIGHT   = 13'd600;

    // Input item
    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
    } pixel_t;

    // Result item
    typedef struct packed {
        logic [GRAY_W-1:0] gray_level;
        logic              escaped;
        logic [ITER_W-1:0] escape_iteration;
    } shade_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch pixel, start coordinate dividers
        logic map_step;  // one quotient bit of both coordinate dividers
        logic init;      // c and z from the quotients
        logic mul;       // register the three products of z
        logic step;      // z = z*z + c, count the iteration
        logic gray;      // d*d and N*N, start gray divider
        logic div_step;  // one quotient bit of the gray divider
        logic out_load;  // fill the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic first_iter;  // no update done yet
        logic at_limit;    // iteration count reached N
        logic escape;      // registered squares sum above 4
    } sts_t;

endpackage

// ===== hdl/mps_ctrl.sv =====
// Sequencer for coordinate mapping, escape-time iteration and gray division.
module mps_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pixel_valid,
    output logic          pixel_ready,
    output logic          shade_valid,
    input  logic          shade_ready,
    input  mps_pkg::sts_t sts,
    output mps_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_INIT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_STEP = 3'd4;
    localparam logic [2:0] ST_GRAY = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam logic [mps_pkg::CNT_W-1:0] MAP_LAST = mps_pkg::CNT_W'(mps_pkg::VAL_W - 1);
    localparam logic [mps_pkg::CNT_W-1:0] DIV_LAST = mps_pkg::CNT_W'(mps_pkg::GRAY_W - 1);

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [mps_pkg::CNT_W-1:0] cnt_reg;
    logic [mps_pkg::CNT_W-1:0] cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_free;

    assign pixel_ready = (state_reg == ST_IDLE);
    assign shade_valid = out_valid_reg;
    assign out_free    = !out_valid_reg || shade_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !shade_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MAP_LAST)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (!sts.first_iter && sts.escape)
                begin
                    state_next = ST_GRAY;
                end
                else if (sts.at_limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_GRAY:
            begin
                cmd.gray   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait until the result register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/mps_datapath.sv =====
// Config registers, coordinate dividers, complex iteration and gray divider.
module mps_datapath
#(
    parameter int MAX_ITER_LIMIT = mps_pkg::MAX_ITER_LIMIT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mps_pkg::CFG_W-1:0]       cfg_data,
    input  mps_pkg::pixel_t                 pixel,
    input  mps_pkg::cmd_t                   cmd,
    output mps_pkg::sts_t                   sts,
    output mps_pkg::shade_t                 shade
);

    localparam int VAL_W  = mps_pkg::VAL_W;
    localparam int FRAC   = mps_pkg::FRAC_BITS;
    localparam int ITER_W = mps_pkg::ITER_W;
    localparam int CFG_W  = mps_pkg::CFG_W;
    localparam int GRAY_W = mps_pkg::GRAY_W;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SQ_W   = PROD_W - FRAC;       // floor-shifted square
    localparam int XP_W   = SQ_W + 1;            // floor-shifted 2*zr*zi
    localparam int SAT_W  = SQ_W + 4;            // room for sums before saturation
    localparam int DIV_W  = CFG_W + mps_pkg::INT_BITS;  // 16 * size
    localparam int OFF_W  = VAL_W + 2;
    localparam int NN_W   = 2 * ITER_W;
    localparam int G_W    = NN_W + GRAY_W;

    localparam int ITER_MAX  = (1 << ITER_W) - 1;
    localparam int LIM       = (MAX_ITER_LIMIT < ITER_MAX) ? MAX_ITER_LIMIT : ITER_MAX;
    localparam logic [ITER_W-1:0] ITER_CLAMP = ITER_W'(LIM);

    localparam logic [VAL_W-1:0] FX_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] FX_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO =
        {{(SAT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    // real offset 1.5, imaginary offset 1.0
    localparam logic signed [OFF_W-1:0] OFF_RE = OFF_W'(3) <<< (FRAC - 1);
    localparam logic signed [OFF_W-1:0] OFF_IM = OFF_W'(1) <<< FRAC;
    localparam logic [SQ_W:0]           ESC_BOUND = (SQ_W + 1)'(4) << FRAC;

    // Clamp a wide signed sum into the Q4.28 range
    function automatic logic signed [VAL_W-1:0] fx_sat(input logic signed [SAT_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = FX_MAX;
        end
        else if (v < SAT_LO)
        begin
            r = FX_MIN;
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [ITER_W-1:0] max_iter_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mps_pkg::RST_MAX_ITER;
            width_reg    <= mps_pkg::RST_WIDTH;
            height_reg   <= mps_pkg::RST_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mps_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                mps_pkg::CFG_WIDTH:    width_reg    <= cfg_data;
                mps_pkg::CFG_HEIGHT:   height_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Coordinate dividers: floor(2*pos * 2^32 / (16*size)), one bit a cycle
    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic [CFG_W-1:0]   num_re;
    logic [CFG_W-1:0]   num_im;
    logic [DIV_W-1:0]   dvs_re_reg;
    logic [DIV_W-1:0]   dvs_im_reg;
    logic [DIV_W-1:0]   rem_re_reg;
    logic [DIV_W-1:0]   rem_im_reg;
    logic [VAL_W-1:0]   q_re_reg;
    logic [VAL_W-1:0]   q_im_reg;
    logic               ovf_re_reg;
    logic               ovf_im_reg;
    logic [DIV_W:0]     sh_re;
    logic [DIV_W:0]     sh_im;
    logic               bit_re;
    logic               bit_im;

    assign w_eff  = (width_reg == '0) ? CFG_W'(1) : width_reg;
    assign h_eff  = (height_reg == '0) ? CFG_W'(1) : height_reg;
    assign num_re = {pixel.pixel_column, 1'b0};
    assign num_im = {pixel.pixel_row, 1'b0};
    assign sh_re  = {rem_re_reg, 1'b0};
    assign sh_im  = {rem_im_reg, 1'b0};
    assign bit_re = (sh_re >= {1'b0, dvs_re_reg});
    assign bit_im = (sh_im >= {1'b0, dvs_im_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvs_re_reg <= {w_eff, {mps_pkg::INT_BITS{1'b0}}};
            dvs_im_reg <= {h_eff, {mps_pkg::INT_BITS{1'b0}}};
            rem_re_reg <= DIV_W'(num_re);
            rem_im_reg <= DIV_W'(num_im);
            ovf_re_reg <= (DIV_W'(num_re) >= {w_eff, {mps_pkg::INT_BITS{1'b0}}});
            ovf_im_reg <= (DIV_W'(num_im) >= {h_eff, {mps_pkg::INT_BITS{1'b0}}});
            q_re_reg   <= '0;
            q_im_reg   <= '0;
        end
        else if (cmd.map_step)
        begin
            rem_re_reg <= bit_re ? DIV_W'(sh_re - {1'b0, dvs_re_reg}) : sh_re[DIV_W-1:0];
            rem_im_reg <= bit_im ? DIV_W'(sh_im - {1'b0, dvs_im_reg}) : sh_im[DIV_W-1:0];
            q_re_reg   <= {q_re_reg[VAL_W-2:0], bit_re};
            q_im_reg   <= {q_im_reg[VAL_W-2:0], bit_im};
        end
    end

    // Offset and saturation of c
    logic signed [OFF_W-1:0] c_re_diff;
    logic signed [OFF_W-1:0] c_im_diff;
    logic signed [VAL_W-1:0] c_re_val;
    logic signed [VAL_W-1:0] c_im_val;

    assign c_re_diff = $signed({2'b00, q_re_reg}) - OFF_RE;
    assign c_im_diff = $signed({2'b00, q_im_reg}) - OFF_IM;
    assign c_re_val  = ovf_re_reg ? FX_MAX
                     : fx_sat({{(SAT_W-OFF_W){c_re_diff[OFF_W-1]}}, c_re_diff});
    assign c_im_val  = ovf_im_reg ? FX_MAX
                     : fx_sat({{(SAT_W-OFF_W){c_im_diff[OFF_W-1]}}, c_im_diff});

    // Iteration datapath
    logic signed [VAL_W-1:0]  cr_reg;
    logic signed [VAL_W-1:0]  ci_reg;
    logic signed [VAL_W-1:0]  zr_reg;
    logic signed [VAL_W-1:0]  zi_reg;
    logic signed [PROD_W-1:0] prr_reg;
    logic signed [PROD_W-1:0] pii_reg;
    logic signed [PROD_W-1:0] pri_reg;
    logic [ITER_W-1:0]        n_reg;
    logic [ITER_W-1:0]        i_reg;
    logic signed [SQ_W-1:0]   sr;
    logic signed [SQ_W-1:0]   si;
    logic signed [XP_W-1:0]   sx;
    logic signed [SAT_W-1:0]  re_sum;
    logic signed [SAT_W-1:0]  im_sum;
    logic [SQ_W:0]            mag_sum;

    // floor shifts of the registered products
    assign sr = prr_reg[PROD_W-1:FRAC];
    assign si = pii_reg[PROD_W-1:FRAC];
    assign sx = pri_reg[PROD_W-1:FRAC-1];

    assign re_sum = {{(SAT_W-SQ_W){sr[SQ_W-1]}}, sr}
                  - {{(SAT_W-SQ_W){si[SQ_W-1]}}, si}
                  + {{(SAT_W-VAL_W){cr_reg[VAL_W-1]}}, cr_reg};
    assign im_sum = {{(SAT_W-XP_W){sx[XP_W-1]}}, sx}
                  + {{(SAT_W-VAL_W){ci_reg[VAL_W-1]}}, ci_reg};

    // squares are never negative
    assign mag_sum = {1'b0, sr} + {1'b0, si};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= (max_iter_reg > ITER_CLAMP) ? ITER_CLAMP : max_iter_reg;
            i_reg <= '0;
        end
        else if (cmd.step)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.init)
        begin
            cr_reg <= c_re_val;
            ci_reg <= c_im_val;
            zr_reg <= c_re_val;
            zi_reg <= c_im_val;
        end
        else if (cmd.step)
        begin
            zr_reg <= fx_sat(re_sum);
            zi_reg <= fx_sat(im_sum);
        end
        if (cmd.mul)
        begin
            prr_reg <= zr_reg * zr_reg;
            pii_reg <= zi_reg * zi_reg;
            pri_reg <= zr_reg * zi_reg;
        end
    end

    assign sts.first_iter = (i_reg == '0);
    assign sts.at_limit   = (i_reg == n_reg);
    assign sts.escape     = (mag_sum > ESC_BOUND);

    // Gray divider: floor(255*d*d / (N*N)), one quotient bit a cycle
    logic [ITER_W-1:0] d_val;
    logic [NN_W-1:0]   dd;
    logic [NN_W-1:0]   nn;
    logic [G_W-1:0]    rem_g_reg;
    logic [G_W-1:0]    trial_g_reg;
    logic [GRAY_W-1:0] gq_reg;
    logic              esc_reg;
    logic              bit_g;

    assign d_val = n_reg - i_reg;
    assign dd    = NN_W'(d_val) * NN_W'(d_val);
    assign nn    = NN_W'(n_reg) * NN_W'(n_reg);
    assign bit_g = (rem_g_reg >= trial_g_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            esc_reg <= 1'b0;
        end
        else if (cmd.gray)
        begin
            esc_reg <= 1'b1;
        end
        if (cmd.gray)
        begin
            rem_g_reg   <= {dd, {GRAY_W{1'b0}}} - G_W'(dd);
            trial_g_reg <= {1'b0, nn, {(GRAY_W-1){1'b0}}};
            gq_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_g_reg   <= bit_g ? (rem_g_reg - trial_g_reg) : rem_g_reg;
            trial_g_reg <= trial_g_reg >> 1;
            gq_reg      <= {gq_reg[GRAY_W-2:0], bit_g};
        end
    end

    // Result register
    mps_pkg::shade_t shade_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (esc_reg)
            begin
                shade_reg.gray_level       <= gq_reg;
                shade_reg.escaped          <= 1'b1;
                shade_reg.escape_iteration <= i_reg - 1'b1;
            end
            else
            begin
                shade_reg <= '0;
            end
        end
    end

    assign shade = shade_reg;

endmodule

// ===== hdl/mandelbrot_pixel_shader_core.sv =====
// Top level of the Mandelbrot escape-time pixel shader.
// One pixel (column, row) in, one gray level out, one pixel at a time. The
// pixel is mapped to c with two 32-step bit-serial dividers, then z = z*z + c
// runs on three 32x32 multipliers with a registered product. A pixel that
// escapes also runs the 8-step gray level divider before its result is
// loaded. The result register lets the next pixel start while the last
// result waits. Configuration writes are always accepted and must happen
// while idle.
module mandelbrot_pixel_shader_core
#(
    parameter int MAX_ITER_LIMIT = mps_pkg::MAX_ITER_LIMIT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  mps_pkg::pixel_t               pixel,
    output logic                          shade_valid,
    input  logic                          shade_ready,
    output mps_pkg::shade_t               shade
);

    mps_pkg::cmd_t cmd;
    mps_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    mps_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .shade_valid (shade_valid),
        .shade_ready (shade_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    mps_datapath
    #(
        .MAX_ITER_LIMIT (MAX_ITER_LIMIT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .sts       (sts),
        .shade     (shade)
    );

    // An inside pixel carries no gray level and no iteration
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && !shade.escaped |-> shade.gray_level == '0
                                         && shade.escape_iteration == '0)
        else $error("inside pixel with nonzero result fields");

    // A pixel transfer starts work, so the input closes next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("input still open after pixel transfer");

    // Loading a result returns the controller to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(shade_valid) |-> pixel_ready)
        else $error("result loaded without returning to idle");

endmodule
